// File: hw/rtl/esm_pkg.sv
package esm_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [1:0] ST_BAD_PRICE = 2'd2;
    localparam logic [1:0] ST_BAD_QTY   = 2'd3;

    localparam int QTY_W      = 31;
    localparam int NOTIONAL_W = 62;
    localparam int RATE_W     = 14;
    localparam int BP_Q_W     = 33;
    localparam int BP_NUM_W   = 76;
    localparam int RATE_NUM_W = 45;

    localparam logic [RATE_W-1:0] BP_FULL = 14'd10000;

    typedef struct packed {
        logic [1:0]            status;
        logic                  sell;
        logic                  no_fill;
        logic                  neg;
        logic                  ovf;
        logic [QTY_W-1:0]      ord;
        logic [QTY_W-1:0]      bench;
        logic [NOTIONAL_W-1:0] base;
    } esm_side_t;

    // x * 10000 as a sum of shifted copies (8192 + 1024 + 512 + 256 + 16).
    function automatic logic [BP_NUM_W-1:0] times_bp(input logic [NOTIONAL_W-1:0] x);
        logic [BP_NUM_W-1:0] xe;
        xe = BP_NUM_W'(x);
        return (xe << 13) + (xe << 10) + (xe << 9) + (xe << 8) + (xe << 4);
    endfunction

endpackage

// File: hw/rtl/esm_div.sv
module esm_div #(
    parameter int NW  = 62,
    parameter int DW  = 31,
    parameter int QW  = 62,
    parameter int LAT = 62
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic [DW-1:0] rem
);
    // Restoring division, one quotient bit per stage; stages past QW only carry.
    logic [DW-1:0] r_reg  [0:LAT-1];
    logic [DW-1:0] r_next [0:LAT-1];
    logic [QW-1:0] q_reg  [0:LAT-1];
    logic [QW-1:0] q_next [0:LAT-1];
    logic [DW-1:0] d_reg  [0:LAT-1];
    logic [DW-1:0] d_next [0:LAT-1];

    always_comb begin
        for (int i = 0; i < LAT; i++) begin
            logic [DW-1:0] sr;
            logic [QW-1:0] sq;
            logic [DW-1:0] sd;
            logic [DW:0]   t;
            if (i == 0) begin
                sr = DW'(num >> QW);
                sq = num[QW-1:0];
                sd = den;
            end else begin
                sr = r_reg[i-1];
                sq = q_reg[i-1];
                sd = d_reg[i-1];
            end
            t = {sr, sq[QW-1]};
            if (i < QW) begin
                if (t >= {1'b0, sd}) begin
                    r_next[i] = DW'(t - {1'b0, sd});
                    q_next[i] = {sq[QW-2:0], 1'b1};
                end else begin
                    r_next[i] = t[DW-1:0];
                    q_next[i] = {sq[QW-2:0], 1'b0};
                end
            end else begin
                r_next[i] = sr;
                q_next[i] = sq;
            end
            d_next[i] = sd;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
            q_reg <= q_next;
            d_reg <= d_next;
        end
    end

    assign quo = q_reg[LAT-1];
    assign rem = r_reg[LAT-1];
endmodule

// File: hw/rtl/esm_delay.sv
module esm_delay #(
    parameter int W   = 8,
    parameter int LAT = 4
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] sh_reg [0:LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sh_reg[0] <= din;
            for (int i = 1; i < LAT; i++) begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    assign dout = sh_reg[LAT-1];
endmodule

// File: hw/rtl/execution_slippage_metrics_unit.sv
// Fill report checker and slippage meter.
// Input channel s_*: one fill report per transaction (side, ordered and filled
// quantity, notional, benchmark price). Output channel m_*: one result per
// report, in order (status, fill rate, average price, price and bp slippage).
// A report passes from input acceptance to m_valid through four front stages
// (check and register, benchmark times filled, absolute difference, scaling
// by 10000), 62 divider stages set by the 62-bit average-price quotient that
// yields one bit per stage, and the output register. The rate-of-fill and
// basis-point dividers run alongside in the same stages.
// Throughput is one report per cycle; a new transaction is taken every cycle
// the output register is empty or being drained.
// When the receiver holds m_ready low with a result waiting, the whole
// pipeline freezes in place and s_ready drops; nothing is dropped or repeated.
// A synchronous active-low reset empties the pipeline; results in flight are
// discarded and m_valid goes low.
module execution_slippage_metrics_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_trade_side,
    input  logic [esm_pkg::QTY_W-1:0]          s_ordered_quantity,
    input  logic [esm_pkg::QTY_W-1:0]          s_filled_quantity,
    input  logic [esm_pkg::NOTIONAL_W-1:0]     s_fill_notional,
    input  logic [esm_pkg::QTY_W-1:0]          s_benchmark_price,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [esm_pkg::RATE_W-1:0]         m_fill_ratio,
    output logic [esm_pkg::NOTIONAL_W-1:0]     m_average_price,
    output logic signed [esm_pkg::NOTIONAL_W:0] m_slippage_price,
    output logic signed [31:0]                 m_slip_basis_pts
);
    import esm_pkg::*;

    localparam int DIV_LAT = NOTIONAL_W;
    localparam int NSTG    = 4 + DIV_LAT + 1;

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv     = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    // Stage A: checks.
    logic [1:0] st_next;
    always_comb begin
        if (s_trade_side > 2'd1) begin
            st_next = ST_BAD_ARG;
        end else if (s_benchmark_price == '0) begin
            st_next = ST_BAD_PRICE;
        end else if (s_ordered_quantity == '0 || s_filled_quantity > s_ordered_quantity) begin
            st_next = ST_BAD_QTY;
        end else if ((s_filled_quantity == '0) ? (s_fill_notional != '0)
                                               : (s_fill_notional == '0)) begin
            st_next = ST_BAD_ARG;
        end else begin
            st_next = ST_OK;
        end
    end

    logic [1:0]            a_status_reg, b_status_reg, c_status_reg, d_status_reg;
    logic                  a_sell_reg, b_sell_reg, c_sell_reg, d_sell_reg;
    logic [QTY_W-1:0]      a_ord_reg, b_ord_reg, c_ord_reg, d_ord_reg;
    logic [QTY_W-1:0]      a_fil_reg, b_fil_reg, c_fil_reg, d_fil_reg;
    logic [QTY_W-1:0]      a_bench_reg, b_bench_reg, c_bench_reg, d_bench_reg;
    logic [NOTIONAL_W-1:0] a_not_reg, b_not_reg, c_not_reg, d_not_reg;
    logic [NOTIONAL_W-1:0] b_base_reg, c_base_reg, d_base_reg;
    logic [NOTIONAL_W-1:0] c_mag_reg;
    logic                  c_neg_reg, d_neg_reg;
    logic [RATE_NUM_W-1:0] c_rnum_reg, d_rnum_reg;
    logic [BP_NUM_W-1:0]   d_bnum_reg;

    logic                  neg_next;
    logic [NOTIONAL_W-1:0] mag_next;

    always_comb begin
        neg_next = b_sell_reg ? (b_base_reg < b_not_reg) : (b_not_reg < b_base_reg);
        mag_next = (b_not_reg >= b_base_reg) ? b_not_reg - b_base_reg
                                             : b_base_reg - b_not_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_status_reg <= st_next;
            a_sell_reg   <= s_trade_side[0];
            a_ord_reg    <= s_ordered_quantity;
            a_fil_reg    <= s_filled_quantity;
            a_bench_reg  <= s_benchmark_price;
            a_not_reg    <= s_fill_notional;

            b_status_reg <= a_status_reg;
            b_sell_reg   <= a_sell_reg;
            b_ord_reg    <= a_ord_reg;
            b_fil_reg    <= a_fil_reg;
            b_bench_reg  <= a_bench_reg;
            b_not_reg    <= a_not_reg;
            b_base_reg   <= NOTIONAL_W'(a_bench_reg) * NOTIONAL_W'(a_fil_reg);

            c_status_reg <= b_status_reg;
            c_sell_reg   <= b_sell_reg;
            c_ord_reg    <= b_ord_reg;
            c_fil_reg    <= b_fil_reg;
            c_bench_reg  <= b_bench_reg;
            c_not_reg    <= b_not_reg;
            c_base_reg   <= b_base_reg;
            c_neg_reg    <= neg_next;
            c_mag_reg    <= mag_next;
            c_rnum_reg   <= RATE_NUM_W'(times_bp(NOTIONAL_W'(b_fil_reg)));

            d_status_reg <= c_status_reg;
            d_sell_reg   <= c_sell_reg;
            d_ord_reg    <= c_ord_reg;
            d_fil_reg    <= c_fil_reg;
            d_bench_reg  <= c_bench_reg;
            d_not_reg    <= c_not_reg;
            d_base_reg   <= c_base_reg;
            d_neg_reg    <= c_neg_reg;
            d_rnum_reg   <= c_rnum_reg;
            d_bnum_reg   <= times_bp(c_mag_reg);
        end
    end

    // Divisors are forced nonzero; results from such reports are masked at the end.
    logic [QTY_W-1:0]      rate_den, avg_den;
    logic [NOTIONAL_W-1:0] bp_den;
    assign rate_den = (d_ord_reg == '0) ? QTY_W'(1) : d_ord_reg;
    assign avg_den  = (d_fil_reg == '0) ? QTY_W'(1) : d_fil_reg;
    assign bp_den   = (d_base_reg == '0) ? NOTIONAL_W'(1) : d_base_reg;

    logic [RATE_W-1:0]     rate_q;
    logic [QTY_W-1:0]      rate_r;
    logic [NOTIONAL_W-1:0] avg_q;
    logic [QTY_W-1:0]      avg_r;
    logic [BP_Q_W-1:0]     bp_q;
    logic [NOTIONAL_W-1:0] bp_r;

    esm_div #(.NW(RATE_NUM_W), .DW(QTY_W), .QW(RATE_W), .LAT(DIV_LAT)) u_rate_div (
        .aclk(aclk), .en(adv), .num(d_rnum_reg), .den(rate_den), .quo(rate_q), .rem(rate_r)
    );

    esm_div #(.NW(NOTIONAL_W), .DW(QTY_W), .QW(NOTIONAL_W), .LAT(DIV_LAT)) u_avg_div (
        .aclk(aclk), .en(adv), .num(d_not_reg), .den(avg_den), .quo(avg_q), .rem(avg_r)
    );

    esm_div #(.NW(BP_NUM_W), .DW(NOTIONAL_W), .QW(BP_Q_W), .LAT(DIV_LAT)) u_bp_div (
        .aclk(aclk), .en(adv), .num(d_bnum_reg), .den(bp_den), .quo(bp_q), .rem(bp_r)
    );

    // A quotient of 2^33 or more saturates regardless of its low bits.
    esm_side_t sb_in, sb_out;
    always_comb begin
        sb_in.status  = d_status_reg;
        sb_in.sell    = d_sell_reg;
        sb_in.no_fill = (d_fil_reg == '0);
        sb_in.neg     = d_neg_reg;
        sb_in.ovf     = (NOTIONAL_W'(d_bnum_reg[BP_NUM_W-1:BP_Q_W]) >= d_base_reg);
        sb_in.ord     = d_ord_reg;
        sb_in.bench   = d_bench_reg;
        sb_in.base    = d_base_reg;
    end

    esm_delay #(.W($bits(esm_side_t)), .LAT(DIV_LAT)) u_side_dly (
        .aclk(aclk), .en(adv), .din(sb_in), .dout(sb_out)
    );

    logic [1:0]                 status_reg;
    logic [RATE_W-1:0]          rate_reg;
    logic [NOTIONAL_W-1:0]      avg_reg;
    logic [NOTIONAL_W:0]        slip_reg;
    logic [31:0]                slip_bp_reg;

    logic [RATE_W-1:0]          rate_rnd;
    logic [BP_Q_W:0]            bp_sum;
    logic [31:0]                bp_val;
    logic [NOTIONAL_W:0]        slip_val;
    logic                       ok, fill_ok;

    always_comb begin
        ok       = (sb_out.status == ST_OK);
        fill_ok  = ok && !sb_out.no_fill;
        rate_rnd = rate_q + RATE_W'({rate_r, 1'b0} >= {1'b0, sb_out.ord});
        bp_sum   = {1'b0, bp_q} + (BP_Q_W + 1)'({bp_r, 1'b0} >= {1'b0, sb_out.base});
        if (sb_out.neg) begin
            if (sb_out.ovf || bp_sum >= (BP_Q_W + 1)'(34'h080000000)) begin
                bp_val = 32'h80000000;
            end else begin
                bp_val = 32'd0 - bp_sum[31:0];
            end
        end else begin
            if (sb_out.ovf || bp_sum > (BP_Q_W + 1)'(34'h07FFFFFFF)) begin
                bp_val = 32'h7FFFFFFF;
            end else begin
                bp_val = bp_sum[31:0];
            end
        end
        if (sb_out.sell) begin
            slip_val = (NOTIONAL_W + 1)'(sb_out.bench) - {1'b0, avg_q};
        end else begin
            slip_val = {1'b0, avg_q} - (NOTIONAL_W + 1)'(sb_out.bench);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            status_reg  <= sb_out.status;
            rate_reg    <= ok ? rate_rnd : '0;
            avg_reg     <= fill_ok ? avg_q : '0;
            slip_reg    <= fill_ok ? slip_val : '0;
            slip_bp_reg <= fill_ok ? bp_val : '0;
        end
    end

    assign m_status         = status_reg;
    assign m_fill_ratio     = rate_reg;
    assign m_average_price  = avg_reg;
    assign m_slippage_price = slip_reg;
    assign m_slip_basis_pts = slip_bp_reg;

    logic unused_rem;
    assign unused_rem = ^avg_r;
endmodule

// File: hw/rtl/esm_checker.sv
module esm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [1:0]                         m_status,
    input logic [esm_pkg::RATE_W-1:0]         m_fill_ratio,
    input logic [esm_pkg::NOTIONAL_W-1:0]     m_average_price,
    input logic signed [esm_pkg::NOTIONAL_W:0] m_slippage_price,
    input logic signed [31:0]                 m_slip_basis_pts
);
    import esm_pkg::*;

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slip_basis_pts)
                                && $stable(m_average_price))
        else $error("result changed while stalled");

    // A rejected report carries only its status.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_fill_ratio == '0 && m_average_price == '0
                                         && m_slippage_price == '0 && m_slip_basis_pts == '0)
        else $error("rejected report has nonzero metrics");

    // Fill rate never exceeds a full fill.
    a_rate_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fill_ratio <= BP_FULL)
        else $error("fill rate above 10000 bp");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // With a stalled full output, no new transaction is taken.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");
endmodule

bind execution_slippage_metrics_unit esm_checker u_esm_checker (.*);

// File: tb/tb_execution_slippage_metrics_unit.sv
module tb_execution_slippage_metrics_unit;
    import esm_pkg::*;

    typedef struct {
        logic [1:0]            status;
        logic [RATE_W-1:0]     rate;
        logic [NOTIONAL_W-1:0] avg;
        logic [NOTIONAL_W:0]   slip;
        logic [31:0]           slip_bp;
    } fill_metrics_t;

    class fill_scoreboard;
        fill_metrics_t expected_q[$];
        int errors = 0;

        // Rounded mag*10000/base, half away from zero, capped above 2^32.
        function automatic logic [127:0] bp_ratio(logic [127:0] mag, logic [127:0] base);
            logic [127:0] num, q, r;
            num = mag * 10000;
            q = num / base;
            r = num % base;
            if (2 * r >= base) q = q + 1;
            if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
            return q;
        endfunction

        function void note(logic [1:0] side, logic [QTY_W-1:0] ord, logic [QTY_W-1:0] filled,
                           logic [NOTIONAL_W-1:0] notional, logic [QTY_W-1:0] bench);
            fill_metrics_t m;
            logic [127:0] base, mag, bp;
            logic neg;
            m = '{ST_OK, '0, '0, '0, '0};
            if (side > 2'd1) m.status = ST_BAD_ARG;
            else if (bench == 0) m.status = ST_BAD_PRICE;
            else if (ord == 0 || filled > ord) m.status = ST_BAD_QTY;
            else if (filled == 0 ? notional != 0 : notional == 0) m.status = ST_BAD_ARG;
            if (m.status == ST_OK) begin
                m.rate = RATE_W'(bp_ratio(128'(filled), 128'(ord)));
                if (filled != 0) begin
                    base = 128'(bench) * 128'(filled);
                    m.avg = notional / filled;
                    if (side == 2'd0) m.slip = {1'b0, m.avg} - (NOTIONAL_W+1)'(bench);
                    else m.slip = (NOTIONAL_W+1)'(bench) - {1'b0, m.avg};
                    neg = (side == 2'd0) ? (128'(notional) < base) : (base < 128'(notional));
                    mag = (128'(notional) >= base) ? 128'(notional) - base
                                                   : base - 128'(notional);
                    bp = bp_ratio(mag, base);
                    if (neg) begin
                        if (bp > 128'h8000_0000) bp = 128'h8000_0000;
                        m.slip_bp = 32'(0 - bp);
                    end else begin
                        if (bp > 128'h7FFF_FFFF) bp = 128'h7FFF_FFFF;
                        m.slip_bp = 32'(bp);
                    end
                end
            end
            expected_q.push_back(m);
        endfunction

        function void check(fill_metrics_t got);
            fill_metrics_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.rate !== e.rate) begin
                $error("fill_ratio exp %0d got %0d", e.rate, got.rate); errors++;
            end
            if (got.avg !== e.avg) begin
                $error("average_price exp %0d got %0d", e.avg, got.avg); errors++;
            end
            if (got.slip !== e.slip) begin
                $error("slippage_price exp %0d got %0d", $signed(e.slip), $signed(got.slip));
                errors++;
            end
            if (got.slip_bp !== e.slip_bp) begin
                $error("slip_basis_pts exp %0d got %0d", $signed(e.slip_bp),
                       $signed(got.slip_bp));
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_valid = 0;
    logic                  s_ready;
    logic [1:0]            s_trade_side = 0;
    logic [QTY_W-1:0]      s_ordered_quantity = 0;
    logic [QTY_W-1:0]      s_filled_quantity = 0;
    logic [NOTIONAL_W-1:0] s_fill_notional = 0;
    logic [QTY_W-1:0]      s_benchmark_price = 0;
    logic                  m_valid;
    logic                  m_ready = 0;
    logic [1:0]            m_status;
    logic [RATE_W-1:0]     m_fill_ratio;
    logic [NOTIONAL_W-1:0] m_average_price;
    logic signed [NOTIONAL_W:0] m_slippage_price;
    logic signed [31:0]    m_slip_basis_pts;

    fill_scoreboard sb = new();
    bit steady = 0;
    int stall_cycles = 0;

    execution_slippage_metrics_unit uut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= steady || ($urandom_range(99) >= 35);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note(s_trade_side, s_ordered_quantity, s_filled_quantity,
                        s_fill_notional, s_benchmark_price);
            if (m_valid && m_ready)
                sb.check('{m_status, m_fill_ratio, m_average_price,
                           m_slippage_price, m_slip_basis_pts});
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= 5000) begin
                $display("execution_slippage_metrics_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic send_report(logic [1:0] side, logic [QTY_W-1:0] ord,
                               logic [QTY_W-1:0] filled, logic [NOTIONAL_W-1:0] notional,
                               logic [QTY_W-1:0] bench);
        if (!steady && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 35);
        end
        s_valid <= 1'b1;
        s_trade_side <= side;
        s_ordered_quantity <= ord;
        s_filled_quantity <= filled;
        s_fill_notional <= notional;
        s_benchmark_price <= bench;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [QTY_W-1:0] pick_qty();
        case ($urandom_range(3))
            0: return QTY_W'($urandom_range(1, 20));
            1: return QTY_W'($urandom_range(1, 100000));
            default: return QTY_W'($urandom) | QTY_W'(1);
        endcase
    endfunction

    task automatic send_random_report();
        logic [1:0]            side;
        logic [QTY_W-1:0]      ord, filled, bench;
        logic [127:0]          base, n;
        logic [NOTIONAL_W-1:0] notional;
        if ($urandom_range(99) < 15) begin
            // Raw noise: every field uniformly random, so most are rejected.
            send_report(2'($urandom), QTY_W'($urandom), QTY_W'($urandom),
                        NOTIONAL_W'({$urandom, $urandom}), QTY_W'($urandom));
            return;
        end
        side = 2'($urandom_range(1));
        ord = pick_qty();
        case ($urandom_range(7))
            0: filled = 0;
            1: filled = ord;
            default: filled = QTY_W'({$urandom, $urandom} % (64'(ord) + 1));
        endcase
        bench = pick_qty();
        base = 128'(bench) * 128'(filled);
        case ($urandom_range(5))
            0: n = base;
            1: n = base + $urandom_range(1000);
            2: n = (base > 1000) ? base - $urandom_range(1000) : base;
            3: n = base + (base >> $urandom_range(1, 12)) - (base >> $urandom_range(1, 12));
            4: n = 128'({$urandom, $urandom} >> $urandom_range(0, 40));
            default: n = base + 128'(filled) * $urandom_range(2000);
        endcase
        if (n >= (128'd1 << NOTIONAL_W)) n = base;
        notional = NOTIONAL_W'(n);
        if (filled == 0) notional = 0;
        else if (notional == 0) notional = 1;
        send_report(side, ord, filled, notional, bench);
    endtask

    localparam logic [QTY_W-1:0]      QMAX = '1;
    localparam logic [NOTIONAL_W-1:0] NMAX = '1;

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: rejections in check order, edge values, ties, saturation.
        send_report(2'd2, 10, 5, 50, 10);
        send_report(2'd3, 0, 0, 0, 0);
        send_report(2'd0, 10, 5, 50, 0);
        send_report(2'd1, 0, 0, 0, 10);
        send_report(2'd0, 10, 11, 110, 10);
        send_report(2'd0, 10, 0, 7, 10);
        send_report(2'd1, 10, 3, 0, 10);
        send_report(2'd0, 10, 0, 0, 10);
        send_report(2'd1, QMAX, 0, 0, QMAX);
        send_report(2'd0, QMAX, QMAX, NMAX, QMAX);
        send_report(2'd1, QMAX, QMAX, NMAX, QMAX);
        send_report(2'd0, 20000, 1, 100, 100);
        send_report(2'd0, 20000, 3, 100, 100);
        send_report(2'd0, 1, 1, 10001, 20000);
        send_report(2'd1, 1, 1, 10001, 20000);
        send_report(2'd0, 1, 1, NMAX, 1);
        send_report(2'd1, 1, 1, NMAX, 1);
        send_report(2'd0, QMAX, 1, 1, QMAX);
        send_report(2'd1, QMAX, 1, 1, QMAX);
        send_report(2'd0, 7, 7, 700, 100);
        send_report(2'd1, 7, 7, 693, 100);
        drain_results();

        for (int i = 0; i < 900; i++) begin
            steady = (i >= 300 && i < 450);
            if (i == 600) drain_results();
            send_random_report();
        end
        steady = 0;
        drain_results();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("execution_slippage_metrics_unit: match");
        else
            $display("execution_slippage_metrics_unit: mismatch");
        $finish;
    end
endmodule
